[rtl/rmth_pkg.sv]
// Package for the running median block: widths, heap depth and sequencer states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rmth_pkg;
	localparam int CAPACITY    = 1024;
	localparam int SAMPLE_BITS = 16;
	localparam int HEAP_DEPTH  = (CAPACITY + 1) / 2;
	localparam int ADDR_BITS   = $clog2(HEAP_DEPTH);
	localparam int CNT_BITS    = $clog2(HEAP_DEPTH + 1);
	localparam int COUNT_BITS  = 11;
	localparam int MED_BITS    = SAMPLE_BITS + 1;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic [ADDR_BITS-1:0] addr_t;
	typedef logic [CNT_BITS-1:0] cnt_t;

	typedef struct packed {
		sample_t    sample;
		logic       stream_start;
	} in_item_t;

	typedef struct packed {
		logic signed [MED_BITS-1:0] median_twice;
		logic [COUNT_BITS-1:0]      sample_count;
		logic                       store_full;
	} out_item_t;

	// Heap operation request to a heap engine.
	typedef enum logic [1:0] {
		OP_NONE,
		OP_PUSH,
		OP_POP
	} heap_op_t;

	typedef struct packed {
		heap_op_t op;
		sample_t  value;
	} heap_req_t;

	typedef struct packed {
		logic    busy;
		sample_t top;
		sample_t popped;
		cnt_t    count;
	} heap_stat_t;

	typedef enum logic [3:0] {
		H_IDLE,
		H_PUSH_RD,
		H_PUSH_CMP,
		H_POP_LAST,
		H_POP_RDL,
		H_POP_RDR,
		H_POP_CMP,
		H_DONE
	} heap_state_t;

	typedef enum logic [3:0] {
		C_IDLE,
		C_DECIDE,
		C_POP_A,
		C_WAIT_POP,
		C_PUSH_B,
		C_WAIT_B,
		C_PUSH_C,
		C_WAIT_C,
		C_RESULT
	} ctl_state_t;
endpackage
`default_nettype wire

[rtl/rmth_if.sv]
// Valid/ready channel interface carrying one payload.
// Depends on rmth_pkg for payload types.
`timescale 1ns / 1ps
`default_nettype none
interface rmth_in_if(input wire logic clk);
	logic                valid;
	logic                ready;
	rmth_pkg::in_item_t  payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface rmth_out_if(input wire logic clk);
	logic                valid;
	logic                ready;
	rmth_pkg::out_item_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface
`default_nettype wire

[rtl/rmth_heap.sv]
// One binary heap in a memory with one write and one read port, with a sift sequencer.
// Depends on rmth_pkg. is_max selects max-heap or min-heap order.
`timescale 1ns / 1ps
`default_nettype none
module rmth_heap (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               is_max,
	input  wire logic               clear,
	input  wire rmth_pkg::heap_req_t req,
	output rmth_pkg::heap_stat_t    stat
);
	import rmth_pkg::*;

	sample_t mem [HEAP_DEPTH];
	sample_t rd_q;
	logic    we;
	addr_t   waddr, raddr;
	sample_t wdata;

	heap_state_t st_q, st_d;
	cnt_t    cnt_q, cnt_d;
	cnt_t    idx_q, idx_d;
	cnt_t    n_q, n_d;
	sample_t val_q, val_d;
	sample_t top_q, top_d;
	sample_t popped_q, popped_d;
	sample_t left_q, left_d;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	function automatic logic ahead(sample_t a, sample_t b, logic mx);
		return mx ? (a > b) : (a < b);
	endfunction

	cnt_t parent, lchild, rchild;
	assign parent = (idx_q - cnt_t'(1)) >> 1;
	assign lchild = cnt_t'({idx_q, 1'b1});
	assign rchild = lchild + cnt_t'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= H_IDLE;
			cnt_q <= '0;
		end else begin
			st_q  <= st_d;
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q    <= idx_d;
		n_q      <= n_d;
		val_q    <= val_d;
		top_q    <= top_d;
		popped_q <= popped_d;
		left_q   <= left_d;
	end

	always_comb begin
		st_d     = st_q;
		cnt_d    = cnt_q;
		idx_d    = idx_q;
		n_d      = n_q;
		val_d    = val_q;
		top_d    = top_q;
		popped_d = popped_q;
		left_d   = left_q;
		we       = 1'b0;
		waddr    = addr_t'(idx_q);
		wdata    = val_q;
		raddr    = addr_t'(parent);
		if (clear)
			cnt_d = '0;
		unique case (st_q)
			H_IDLE: begin
				if (req.op == OP_PUSH) begin
					idx_d = cnt_q;
					val_d = req.value;
					cnt_d = cnt_q + cnt_t'(1);
					if (cnt_q == '0) begin
						we    = 1'b1;
						waddr = '0;
						wdata = req.value;
						top_d = req.value;
						st_d  = H_DONE;
					end else begin
						st_d = H_PUSH_RD;
					end
				end else if (req.op == OP_POP) begin
					popped_d = top_q;
					n_d      = cnt_q - cnt_t'(1);
					cnt_d    = cnt_q - cnt_t'(1);
					idx_d    = '0;
					raddr    = addr_t'(cnt_q - cnt_t'(1));
					st_d     = H_POP_LAST;
				end
			end
			H_PUSH_RD: begin
				// Parent read issued this cycle; data in rd_q next cycle.
				raddr = addr_t'(parent);
				st_d  = H_PUSH_CMP;
			end
			H_PUSH_CMP: begin
				if (ahead(val_q, rd_q, is_max)) begin
					we    = 1'b1;
					waddr = addr_t'(idx_q);
					wdata = rd_q;
					idx_d = parent;
					if (parent == '0) begin
						st_d = H_DONE;
						we   = 1'b1;
					end else begin
						st_d = H_PUSH_RD;
					end
				end else begin
					we    = 1'b1;
					wdata = val_q;
					if (idx_q == '0)
						top_d = val_q;
					st_d  = H_DONE;
				end
			end
			H_POP_LAST: begin
				val_d = rd_q;
				if (n_q == '0) begin
					st_d = H_DONE;
				end else begin
					raddr = addr_t'(lchild);
					st_d  = (lchild >= n_q) ? H_POP_CMP : H_POP_RDL;
				end
			end
			H_POP_RDL: begin
				left_d = rd_q;
				raddr  = addr_t'(rchild);
				st_d   = H_POP_RDR;
			end
			H_POP_RDR: begin
				// rd_q holds the right child now.
				if (rchild < n_q && ahead(rd_q, left_q, is_max)) begin
					if (ahead(rd_q, val_q, is_max)) begin
						we = 1'b1; wdata = rd_q;
						if (idx_q == '0) top_d = rd_q;
						idx_d = rchild;
					end else begin
						st_d = H_POP_CMP;
					end
				end else if (ahead(left_q, val_q, is_max)) begin
					we = 1'b1; wdata = left_q;
					if (idx_q == '0) top_d = left_q;
					idx_d = lchild;
				end else begin
					st_d = H_POP_CMP;
				end
				if (we) begin
					st_d = H_POP_LAST;
					n_d  = n_q;
				end
			end
			H_POP_CMP: begin
				we = 1'b1; wdata = val_q;
				if (idx_q == '0) top_d = val_q;
				st_d = H_DONE;
			end
			H_DONE: st_d = H_IDLE;
			default: st_d = H_IDLE;
		endcase
		// Re-read of the last element is skipped after a descent step.
		if (st_q == H_POP_RDR && st_d == H_POP_LAST) begin
			st_d  = (cnt_t'({idx_d, 1'b1}) >= n_q) ? H_POP_CMP : H_POP_RDL;
			raddr = addr_t'(cnt_t'({idx_d, 1'b1}));
		end
		if (st_q == H_PUSH_CMP && we && st_d == H_DONE && idx_d == '0
				&& ahead(val_q, rd_q, is_max)) begin
			// Reached the root while moving up; the value becomes the top.
			top_d = val_q;
			st_d  = H_POP_CMP;
		end
	end

	assign stat.busy   = (st_q != H_IDLE);
	assign stat.top    = top_q;
	assign stat.popped = popped_q;
	assign stat.count  = cnt_q;
endmodule
`default_nettype wire

[rtl/running_median_two_heaps.sv]
// Top level of the running median: sequencer over two heap engines.
// Depends on rmth_pkg, rmth_if and rmth_heap.
//
//  channel  dir  payload
//  in_ch    in   sample, stream_start
//  out_ch   out  median_twice, sample_count, store_full
//
// A request is one push, or a pop plus two pushes that rebalance the heaps,
// each sift walking one heap level at a time through the heap memory. A
// dropped sample goes straight to its result.
// Reset clears the counts; heap memories are not cleared.
// in_ch is not ready while a request is in work or its result waits.
`timescale 1ns / 1ps
`default_nettype none
module running_median_two_heaps (
	input wire logic   clk,
	input wire logic   arst_n,
	rmth_in_if.sink    in_ch,
	rmth_out_if.source out_ch
);
	import rmth_pkg::*;

	ctl_state_t st_q, st_d;
	heap_req_t  lreq, ureq;
	heap_stat_t lst, ust;
	logic       clr;
	sample_t    x_q, x_d;
	logic       full_q, full_d;
	logic       vc_q, vc_d;       // upper pop: x goes up first, then the popped upper top goes down
	logic       ov_q;
	out_item_t  res_q, res_d;

	rmth_heap u_lo (.clk, .arst_n, .is_max(1'b1), .clear(clr), .req(lreq), .stat(lst));
	rmth_heap u_hi (.clk, .arst_n, .is_max(1'b0), .clear(clr), .req(ureq), .stat(ust));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= C_IDLE;
			ov_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (out_ch.valid && out_ch.ready) ov_q <= 1'b0;
			else if (st_q == C_RESULT) ov_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		x_q    <= x_d;
		full_q <= full_d;
		vc_q   <= vc_d;
		res_q  <= res_d;
	end

	cnt_t lc, uc;
	assign lc = lst.count;
	assign uc = ust.count;
	logic [COUNT_BITS-1:0] total;
	assign total = COUNT_BITS'(lc) + COUNT_BITS'(uc);

	always_comb begin
		st_d   = st_q;
		x_d    = x_q;
		full_d = full_q;
		vc_d   = vc_q;
		res_d  = res_q;
		clr    = 1'b0;
		lreq   = '{op: OP_NONE, value: x_q};
		ureq   = '{op: OP_NONE, value: x_q};
		in_ch.ready = (st_q == C_IDLE) && !ov_q;
		unique case (st_q)
			C_IDLE: if (in_ch.valid && in_ch.ready) begin
				x_d = in_ch.payload.sample;
				clr = in_ch.payload.stream_start;
				st_d = C_DECIDE;
			end
			C_DECIDE: begin
				full_d = (32'(total) >= CAPACITY);
				vc_d = 1'b0;
				st_d = C_RESULT;
				if (!full_d) begin
					if (lc == '0 || x_q <= lst.top) begin
						if (lc > uc) begin
							lreq.op = OP_POP;
							st_d = C_WAIT_POP;
						end else begin
							lreq.op = OP_PUSH; st_d = C_WAIT_C;
						end
					end else if (lc > uc) begin
						ureq.op = OP_PUSH; st_d = C_WAIT_C;
					end else if (uc == '0 || x_q <= ust.top) begin
						lreq.op = OP_PUSH; st_d = C_WAIT_C;
					end else begin
						ureq.op = OP_POP;
						vc_d = 1'b1;
						st_d = C_WAIT_POP;
					end
				end
			end
			C_WAIT_POP: if (!lst.busy && !ust.busy) st_d = C_PUSH_B;
			C_PUSH_B: begin
				// Pushes x after an upper pop, or the popped lower top upward.
				ureq.op    = OP_PUSH;
				ureq.value = vc_q ? x_q : lst.popped;
				st_d = C_WAIT_B;
			end
			C_WAIT_B: if (!ust.busy) st_d = C_PUSH_C;
			C_PUSH_C: begin
				lreq.op    = OP_PUSH;
				lreq.value = vc_q ? ust.popped : x_q;
				st_d = C_WAIT_C;
			end
			C_WAIT_C: if (!lst.busy && !ust.busy) st_d = C_RESULT;
			C_RESULT: begin
				if (lc > uc)
					res_d.median_twice = {lst.top, 1'b0};
				else if (lc != '0)
					res_d.median_twice = MED_BITS'(lst.top) + MED_BITS'(ust.top);
				else
					res_d.median_twice = '0;
				res_d.sample_count = total;
				res_d.store_full   = full_q;
				st_d = C_IDLE;
			end
			default: st_d = C_IDLE;
		endcase
	end

	assign out_ch.valid   = ov_q;
	assign out_ch.payload = res_q;
endmodule
`default_nettype wire

[dv/tb_top.sv]
// Testbench for the running median block: drives samples over in_ch, predicts the median.
// Depends on rmth_pkg, rmth_if and the running_median_two_heaps RTL.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	import rmth_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rmth_in_if  in_ch(clk);
	rmth_out_if out_ch(clk);

	running_median_two_heaps dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Predictor: the multiset of stored samples is kept sorted, which gives the
	// same median as any correct pair of heaps.
	int sorted_samples[$];
	out_item_t median_queue[$];
	int errors = 0;
	int sent = 0;
	int checked = 0;
	int full_seen = 0;
	int idle_cycles = 0;
	bit sink_stall_long = 0;

	function automatic out_item_t predict_median(sample_t s, logic start);
		out_item_t r;
		int v, pos, n;
		logic signed [MED_BITS-1:0] m;
		v = int'(s);
		if (start) sorted_samples.delete();
		r.store_full = 1'b0;
		if (sorted_samples.size() >= CAPACITY) begin
			r.store_full = 1'b1;
		end else begin
			pos = 0;
			while (pos < sorted_samples.size() && sorted_samples[pos] < v) pos++;
			sorted_samples.insert(pos, v);
		end
		n = sorted_samples.size();
		if (n % 2 == 1) m = MED_BITS'(2 * sorted_samples[n / 2]);
		else m = MED_BITS'(sorted_samples[n / 2 - 1] + sorted_samples[n / 2]);
		r.median_twice = m;
		r.sample_count = n[COUNT_BITS-1:0];
		return r;
	endfunction

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 60) return 0;
		if (p < 92) return $urandom_range(1, 4);
		return $urandom_range(10, 80);
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_sample(sample_t s, logic start);
		int g;
		g = gap_len();
		if (g != 0) begin
			in_ch.valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.payload <= '{sample: s, stream_start: start};
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		median_queue.push_back(predict_median(s, start));
		sent++;
		@(negedge clk);
	endtask

	// Result checker and receiver-side stalls.
	always @(posedge clk) begin
		out_item_t exp_r;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (median_queue.size() == 0) begin
				$display("%0t: result with nothing expected: %p", $time, out_ch.payload);
				errors++;
			end else begin
				exp_r = median_queue.pop_front();
				checked++;
				if (out_ch.payload.store_full) full_seen++;
				if (out_ch.payload.median_twice !== exp_r.median_twice)
					$display("%0t: median_twice expected %0d actual %0d", $time,
						exp_r.median_twice, out_ch.payload.median_twice);
				if (out_ch.payload.sample_count !== exp_r.sample_count)
					$display("%0t: sample_count expected %0d actual %0d", $time,
						exp_r.sample_count, out_ch.payload.sample_count);
				if (out_ch.payload.store_full !== exp_r.store_full)
					$display("%0t: store_full expected %0d actual %0d", $time,
						exp_r.store_full, out_ch.payload.store_full);
				if (out_ch.payload !== exp_r) errors++;
			end
		end
	end

	always @(negedge clk) begin
		int p;
		p = $urandom_range(0, 99);
		if (sink_stall_long) out_ch.ready <= (p < 15);
		else out_ch.ready <= (p < 75);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog: nothing accepted for %0d cycles", WATCHDOG_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic test_directed();
		sample_t edge_vals[8];
		edge_vals = '{16'sh7fff, -16'sd32768, 16'sd0, -16'sd1, 16'sd1, 16'sh7fff,
			-16'sd32768, 16'sd5};
		// First request after reset without stream_start starts a stream.
		send_sample(16'sd100, 1'b0);
		send_sample(16'sd100, 1'b0);
		send_sample(16'sd100, 1'b0);
		foreach (edge_vals[i]) send_sample(edge_vals[i], 1'b0);
		send_sample(-16'sd32768, 1'b1);
		send_sample(-16'sd32768, 1'b0);
		send_sample(16'sh7fff, 1'b1);
		send_sample(16'sh7fff, 1'b0);
		send_sample(16'sh5555, 1'b1);
		send_sample(16'shaaaa, 1'b0);
		send_sample(16'sd7, 1'b1);
	endtask

	task automatic test_random_streams();
		int len;
		while (sent < 90) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 60);
			sink_stall_long = ($urandom_range(0, 7) == 0);
			for (int i = 0; i < len; i++) begin
				case ($urandom_range(0, 3))
					0: send_sample(sample_t'($urandom), (i == 0));
					1: send_sample(sample_t'($urandom_range(0, 15) - 8), (i == 0));
					2: send_sample($urandom_range(0, 1) ? 16'sh7fff : -16'sd32768, (i == 0));
					default: send_sample(sample_t'($urandom_range(0, 400) - 200),
						(i == 0) || ($urandom_range(0, 99) == 0));
				endcase
			end
		end
		sink_stall_long = 0;
	endtask

	task automatic test_capacity();
		// Fill the store, push past capacity, then restart while full.
		send_sample(sample_t'($urandom), 1'b1);
		for (int i = 1; i < CAPACITY; i++) send_sample(sample_t'($urandom), 1'b0);
		for (int i = 0; i < 20; i++) send_sample(sample_t'($urandom), 1'b0);
		send_sample(16'sd3, 1'b1);
		send_sample(-16'sd3, 1'b0);
	endtask

	initial begin
		int waited;
		in_ch.valid = 1'b0;
		in_ch.payload = '0;
		out_ch.ready = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random_streams();
		test_capacity();
		in_ch.valid <= 1'b0;
		waited = 0;
		while (median_queue.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d requests, checked %0d results, %0d with the store full.",
			sent, checked, full_seen);
		if (errors == 0 && median_queue.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches, %0d results missing", errors, median_queue.size());
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
`default_nettype wire
